>>> rtl/cfr_pkg.sv
// ----------------------------------------------------------------------------
// cfr_pkg
// Types and constants shared by the command frame receiver.
// ----------------------------------------------------------------------------
package cfr_pkg;

  // frame bytes
  localparam logic [7:0] HDR_FIRST    = 8'hAA;
  localparam logic [7:0] HDR_SECOND   = 8'hAF;
  localparam logic [7:0] FUNC_BOUND   = 8'hF1;
  localparam logic [7:0] LENGTH_BOUND = 8'd50;

  // parser phases
  localparam logic [2:0] PH_HDR_FIRST  = 3'd0;
  localparam logic [2:0] PH_HDR_SECOND = 3'd1;
  localparam logic [2:0] PH_FUNC       = 3'd2;
  localparam logic [2:0] PH_LENGTH     = 3'd3;
  localparam logic [2:0] PH_PAYLOAD    = 3'd4;
  localparam logic [2:0] PH_CHECK      = 3'd5;

  // function codes with a meaning
  localparam logic [7:0] FN_DIRECTION = 8'h02;
  localparam logic [7:0] FN_SPEED     = 8'h03;
  localparam logic [7:0] FN_LIGHTS    = 8'h04;
  localparam logic [7:0] FN_PAN       = 8'h05;
  localparam logic [7:0] FN_POWER     = 8'h06;
  localparam logic [7:0] FN_HEARTBEAT = 8'h09;
  localparam logic [7:0] FN_ACK_FIRST = 8'h13;
  localparam logic [7:0] FN_ACK_LAST  = 8'h15;

  localparam logic [7:0] HEARTBEAT_MARK = 8'd99;
  localparam logic [7:0] POWER_ON       = 8'd1;

  // sum of the fixed acknowledgement bytes AA, AA, EF, 02
  localparam logic [7:0] ACK_FIXED_SUM = 8'h45;

  localparam logic [7:0]  LIGHT_FULL  = 8'd100;
  localparam logic [13:0] LIGHT_SCALE = 14'd100;
  localparam logic [13:0] LIGHT_MAX   = 14'd10000;

  // command kinds
  localparam logic [2:0] KIND_DIRECTION = 3'd0;
  localparam logic [2:0] KIND_SPEED     = 3'd1;
  localparam logic [2:0] KIND_LIGHTS    = 3'd2;
  localparam logic [2:0] KIND_PAN       = 3'd3;
  localparam logic [2:0] KIND_POWER     = 3'd4;
  localparam logic [2:0] KIND_HEARTBEAT = 3'd5;
  localparam logic [2:0] KIND_ACK       = 3'd6;

  typedef logic [7:0] slots_t [4];

  // completed frame handed from parser to decoder
  typedef struct packed {
    logic [7:0] function_code;
    logic [7:0] running_sum;
    logic [7:0] checksum;
    logic [7:0] slot0;
    logic [7:0] slot1;
    logic [7:0] slot2;
    logic [7:0] slot3;
  } frame_t;

  function automatic logic [13:0] light_value(logic [7:0] b);
    logic [6:0] d;
    d = 7'(LIGHT_FULL - b);
    if (b > LIGHT_FULL) return LIGHT_MAX;
    return 14'(d) * LIGHT_SCALE;
  endfunction

endpackage

>>> rtl/cfr_if.sv
// ----------------------------------------------------------------------------
// cfr_if
// Valid/ready channels for received bytes and decoded commands.
// ----------------------------------------------------------------------------
interface cfr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink (input valid, input byte_in, output ready);
endinterface

interface cfr_cmd_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command_kind;
  logic [15:0] command_value;
  logic [13:0] light_a;
  logic [13:0] light_b;
  logic [13:0] light_c;
  logic [13:0] light_d;
  logic [7:0]  ack_function;
  logic [7:0]  ack_sum;
  logic [7:0]  ack_check;

  modport source (
    output valid, output command_kind, output command_value,
    output light_a, output light_b, output light_c, output light_d,
    output ack_function, output ack_sum, output ack_check,
    input ready
  );
  modport sink (
    input valid, input command_kind, input command_value,
    input light_a, input light_b, input light_c, input light_d,
    input ack_function, input ack_sum, input ack_check,
    output ready
  );
endinterface

>>> rtl/cfr_parser.sv
// ----------------------------------------------------------------------------
// cfr_parser
// Byte-wise frame state machine with a register holding the last frame.
// ----------------------------------------------------------------------------
module cfr_parser (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  logic [7:0]    byte_in,
  input  logic          advance,
  output logic          frame_valid,
  output cfr_pkg::frame_t frame
);
  import cfr_pkg::*;

  logic [2:0] phase, phase_next;
  logic [5:0] bytes_left, bytes_left_next;
  logic [5:0] payload_count, payload_count_next;
  logic [7:0] running_sum, running_sum_next;
  logic [7:0] function_code, function_code_next;
  slots_t     slots, slots_next;
  logic       frame_load;
  logic       slot_store;
  logic [7:0] sum_add;

  assign sum_add    = running_sum + byte_in;
  assign slot_store = (payload_count < 6'd4);

  always_comb begin
    phase_next         = PH_HDR_FIRST;
    bytes_left_next    = bytes_left;
    payload_count_next = payload_count;
    running_sum_next   = running_sum;
    function_code_next = function_code;
    slots_next         = slots;
    frame_load         = 1'b0;
    unique case (phase)
      PH_HDR_FIRST: begin
        if (byte_in == HDR_FIRST) begin
          phase_next       = PH_HDR_SECOND;
          running_sum_next = byte_in;
        end
      end
      PH_HDR_SECOND: begin
        if (byte_in == HDR_SECOND) begin
          phase_next       = PH_FUNC;
          running_sum_next = sum_add;
        end
      end
      PH_FUNC: begin
        if (byte_in < FUNC_BOUND) begin
          phase_next         = PH_LENGTH;
          function_code_next = byte_in;
          running_sum_next   = sum_add;
        end
      end
      PH_LENGTH: begin
        if (byte_in < LENGTH_BOUND) begin
          phase_next         = PH_PAYLOAD;
          bytes_left_next    = byte_in[5:0];
          payload_count_next = '0;
          running_sum_next   = sum_add;
        end
      end
      PH_PAYLOAD: begin
        // zero length drops the frame on whatever byte comes next
        if (bytes_left != '0) begin
          bytes_left_next    = bytes_left - 6'd1;
          payload_count_next = payload_count + 6'd1;
          running_sum_next   = sum_add;
          if (slot_store) slots_next[payload_count[1:0]] = byte_in;
          phase_next = (bytes_left == 6'd1) ? PH_CHECK : PH_PAYLOAD;
        end
      end
      PH_CHECK: begin
        // short frames overwrite the next slot with their checksum
        if (slot_store) slots_next[payload_count[1:0]] = byte_in;
        frame_load = 1'b1;
      end
      default: phase_next = PH_HDR_FIRST;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HDR_FIRST;
      bytes_left    <= '0;
      payload_count <= '0;
      running_sum   <= '0;
      function_code <= '0;
      slots         <= '{default: 8'd0};
      frame_valid   <= 1'b0;
    end else begin
      if (accept) begin
        phase         <= phase_next;
        bytes_left    <= bytes_left_next;
        payload_count <= payload_count_next;
        running_sum   <= running_sum_next;
        function_code <= function_code_next;
        slots         <= slots_next;
      end
      if (accept && frame_load) frame_valid <= 1'b1;
      else if (advance)         frame_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && frame_load) begin
      frame.function_code <= function_code;
      frame.running_sum   <= running_sum;
      frame.checksum      <= byte_in;
      frame.slot0         <= slots_next[0];
      frame.slot1         <= slots_next[1];
      frame.slot2         <= slots_next[2];
      frame.slot3         <= slots_next[3];
    end
  end

endmodule

>>> rtl/cfr_decode.sv
// ----------------------------------------------------------------------------
// cfr_decode
// Turns a completed frame into a command word and holds it for the sink.
// ----------------------------------------------------------------------------
module cfr_decode (
  input  logic            clk,
  input  logic            rst,
  input  logic [15:0]     speed_limit,
  input  logic            frame_valid,
  input  cfr_pkg::frame_t frame,
  output logic            load_ok,
  cfr_cmd_if.source       cmd
);
  import cfr_pkg::*;

  logic        hit;
  logic [2:0]  kind;
  logic [15:0] value;
  logic [13:0] la, lb, lc, ld;
  logic [7:0]  afn, asum, achk;
  logic [15:0] speed;

  assign load_ok = !cmd.valid || cmd.ready;
  assign speed   = {frame.slot0, frame.slot1};

  always_comb begin
    hit   = 1'b0;
    kind  = KIND_DIRECTION;
    value = '0;
    la    = '0;
    lb    = '0;
    lc    = '0;
    ld    = '0;
    afn   = '0;
    asum  = '0;
    achk  = '0;
    if (frame.checksum == frame.running_sum) begin
      unique case (frame.function_code) inside
        FN_DIRECTION: begin
          hit   = 1'b1;
          kind  = KIND_DIRECTION;
          value = 16'(frame.slot0);
        end
        FN_SPEED: begin
          hit   = 1'b1;
          kind  = KIND_SPEED;
          value = (speed > speed_limit) ? 16'd0 : speed;
        end
        FN_LIGHTS: begin
          hit  = 1'b1;
          kind = KIND_LIGHTS;
          la   = light_value(frame.slot0);
          lb   = light_value(frame.slot1);
          lc   = light_value(frame.slot2);
          ld   = light_value(frame.slot3);
        end
        FN_PAN: begin
          hit   = 1'b1;
          kind  = KIND_PAN;
          value = 16'(frame.slot0);
        end
        FN_POWER: begin
          hit   = 1'b1;
          kind  = KIND_POWER;
          value = 16'(frame.slot0 == POWER_ON);
        end
        FN_HEARTBEAT: begin
          hit  = (frame.slot0 == HEARTBEAT_MARK);
          kind = KIND_HEARTBEAT;
        end
        [FN_ACK_FIRST:FN_ACK_LAST]: begin
          hit  = 1'b1;
          kind = KIND_ACK;
          afn  = frame.function_code;
          asum = frame.running_sum;
          achk = ACK_FIXED_SUM + frame.function_code + frame.running_sum;
        end
        default: hit = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd.valid <= 1'b0;
    end else if (load_ok) begin
      cmd.valid <= frame_valid && hit;
    end
  end

  always_ff @(posedge clk) begin
    if (load_ok) begin
      cmd.command_kind  <= kind;
      cmd.command_value <= value;
      cmd.light_a       <= la;
      cmd.light_b       <= lb;
      cmd.light_c       <= lc;
      cmd.light_d       <= ld;
      cmd.ack_function  <= afn;
      cmd.ack_sum       <= asum;
      cmd.ack_check     <= achk;
    end
  end

endmodule

>>> rtl/command_frame_receiver.sv
// ----------------------------------------------------------------------------
// command_frame_receiver
// Parses serial command frames and emits one decoded command per good frame.
// ----------------------------------------------------------------------------
// Usage:
//   rx carries one received byte per word (valid/ready). cmd carries one
//   decoded command per word; fields a command kind does not use are zero.
//   speed_limit_we/speed_limit_wdata write the speed limit; write it only
//   while no frame is in flight.
// Throughput: one byte per cycle, sustained, as long as cmd is drained.
// Path: when a frame's checksum byte is accepted, the frame register loads
//   with that byte; the command register then loads from the frame register
//   as soon as cmd can take it, and the command appears on cmd.
// Stall: while cmd is held, the parser keeps taking bytes until the next
//   frame completes into the frame register; from then on rx drops ready
//   until cmd drains.
// Reset: parser returns to header search, payload slots clear, speed limit
//   returns to 20000, both registers empty.
// ----------------------------------------------------------------------------
module command_frame_receiver (
  input  logic        clk,
  input  logic        rst,
  input  logic        speed_limit_we,
  input  logic [15:0] speed_limit_wdata,
  cfr_byte_if.sink    rx,
  cfr_cmd_if.source   cmd
);
  import cfr_pkg::*;

  logic [15:0] speed_limit;
  logic        frame_valid;
  frame_t      frame;
  logic        load_ok;
  logic        accept;

  assign rx.ready = !frame_valid || load_ok;
  assign accept   = rx.valid && rx.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      speed_limit <= 16'd20000;
    end else if (speed_limit_we) begin
      speed_limit <= speed_limit_wdata;
    end
  end

  cfr_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .byte_in     (rx.byte_in),
    .advance     (load_ok),
    .frame_valid (frame_valid),
    .frame       (frame)
  );

  cfr_decode u_decode (
    .clk         (clk),
    .rst         (rst),
    .speed_limit (speed_limit),
    .frame_valid (frame_valid),
    .frame       (frame),
    .load_ok     (load_ok),
    .cmd         (cmd)
  );

`ifndef SYNTH
  a_rise_from_frame: assert property (@(posedge clk) disable iff (rst)
    $rose(cmd.valid) |-> $past(frame_valid))
    else $error("command appeared without a completed frame");

  a_lights_only: assert property (@(posedge clk) disable iff (rst)
    (cmd.valid && cmd.command_kind != KIND_LIGHTS) |->
      (cmd.light_a == 14'd0 && cmd.light_d == 14'd0))
    else $error("light fields set on a non-light command");

  a_ack_check: assert property (@(posedge clk) disable iff (rst)
    (cmd.valid && cmd.command_kind == KIND_ACK) |->
      (cmd.ack_check == 8'(ACK_FIXED_SUM + cmd.ack_function + cmd.ack_sum)))
    else $error("acknowledge checksum inconsistent");

  a_frame_held: assert property (@(posedge clk) disable iff (rst)
    (frame_valid && !load_ok) |=> (frame_valid && $stable(frame)))
    else $error("pending frame lost while command stalled");
`endif

endmodule
